[rtl/tkm_pkg.sv]
// Shared types, constants and the magnitude rank function for the top-K row selector.
// Used by the channel interfaces, the sift comparator and the top level; depends on nothing.

package tkm_pkg;

   localparam int DEFAULT_MAX_KEEP = 64;

   localparam int VALUE_W    = 32;
   localparam int INDEX_W    = 16;
   localparam int NF_W       = 16;
   localparam int KC_W       = 7;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // Cleared bit pattern of infinity; anything above it is a NaN.
   localparam logic [VALUE_W-1:0] MAG_INF = 32'h7F80_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH = 1'b0,
      CSR_KEEP_COUNT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } entry_type;

   // Decision of one compare step of the sift.
   typedef struct packed {
      logic pick_right;
      logic descend;
   } sift_dec_type;

   // A NaN ranks lowest (0); every other value ranks as its magnitude plus one.
   function automatic logic [VALUE_W-1:0] rank_of(input logic [VALUE_W-1:0] bits);
      logic [VALUE_W-1:0] mag;
      mag = {1'b0, bits[VALUE_W-2:0]};
      if (mag > MAG_INF) begin
         return '0;
      end
      return mag + VALUE_W'(1);
   endfunction

endpackage

[rtl/tkm_req_if.sv]
// Input channel of the top-K row selector: valid/ready handshake and one float32 pattern.
// Depends on tkm_pkg for the field width.

interface tkm_req_if;
   logic                        valid;
   logic                        ready;
   logic [tkm_pkg::VALUE_W-1:0] value_bits;

   modport source (output valid, output value_bits, input ready);
   modport sink (input valid, input value_bits, output ready);
endinterface

[rtl/tkm_rsp_if.sv]
// Result channel of the top-K row selector: valid/ready handshake and one kept pair.
// Depends on tkm_pkg for the field widths.

interface tkm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tkm_pkg::INDEX_W-1:0] feature_index;
   logic [tkm_pkg::VALUE_W-1:0] kept_value_bits;
   logic                        last_of_row;

   modport source (output valid, output feature_index, output kept_value_bits,
                   output last_of_row, input ready);
   modport sink (input valid, input feature_index, input kept_value_bits,
                 input last_of_row, output ready);
endinterface

[rtl/tkm_sift_cmp.sv]
// Shared magnitude compare unit of the heap: picks the smaller child and decides a descent.
// Depends on tkm_pkg for the entry type, the decision struct and rank_of.

module tkm_sift_cmp (
   input  tkm_pkg::entry_type    left,
   input  tkm_pkg::entry_type    right,
   input  tkm_pkg::entry_type    carry,
   input  logic                  right_ok,
   output tkm_pkg::sift_dec_type dec
);

   logic [tkm_pkg::VALUE_W-1:0] rank_l;
   logic [tkm_pkg::VALUE_W-1:0] rank_r;
   logic [tkm_pkg::VALUE_W-1:0] rank_c;
   logic [tkm_pkg::VALUE_W-1:0] rank_child;

   assign rank_l = tkm_pkg::rank_of(left.value);
   assign rank_r = tkm_pkg::rank_of(right.value);
   assign rank_c = tkm_pkg::rank_of(carry.value);

   // The right child wins only when it is strictly smaller, so ties go left.
   assign dec.pick_right = right_ok && (rank_r < rank_l);
   assign rank_child     = dec.pick_right ? rank_r : rank_l;
   assign dec.descend    = rank_child < rank_c;

endmodule

[rtl/topk_magnitude_row_select.sv]
// Top-K magnitude row selector. Float32 patterns arrive one item at a time; each row is as
// long as the row length register says, and for each row the keep_count values of largest
// magnitude (NaN ranks lowest) are kept in a binary min-heap held in a MAX_KEEP-entry RAM
// (64 entries by default) with two read ports. Each item that fills the heap is written
// straight into the RAM; when more than one value is kept, the item that completes the heap
// starts a bottom-up build that sinks each parent node in turn, from the last parent back to
// the root. A later item is compared against the root and dropped when it does not outrank it;
// else it replaces the root and sinks down through the heap. Each sift level is one RAM read
// of both children and one pass through the single shared compare unit. At the row end the
// kept pairs leave in heap order, each read from the RAM and then loaded into the output
// register once that register is free; no input item is taken until the last result item of
// the row is in the output register.
// Depends on tkm_pkg, tkm_req_if, tkm_rsp_if and tkm_sift_cmp.

module topk_magnitude_row_select #(
   parameter int MAX_KEEP = tkm_pkg::DEFAULT_MAX_KEEP
) (
   input  logic                           clock,
   input  logic                           reset,
   tkm_req_if.sink                        req_ch,
   tkm_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [tkm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tkm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int KW = $clog2(MAX_KEEP + 1);
   localparam int CW = KW + 1;
   localparam int RW = tkm_pkg::NF_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_ROOT_CMP = 8'b0000_0010,
      ST_SIFT_RD  = 8'b0000_0100,
      ST_SIFT_CMP = 8'b0000_1000,
      ST_BUILD_RD = 8'b0001_0000,
      ST_BUILD_LD = 8'b0010_0000,
      ST_EMIT_RD  = 8'b0100_0000,
      ST_EMIT_LD  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [tkm_pkg::NF_W-1:0] nf_ff, nf_in;
   logic [tkm_pkg::KC_W-1:0] kc_ff, kc_in;
   logic [tkm_pkg::NF_W-1:0] pos_ff, pos_in;
   logic                     last_ff, last_in;
   logic                     building_ff, building_in;
   logic [AW-1:0]            p_ff, p_in;
   logic [AW-1:0]            pb_ff, pb_in;
   logic [AW-1:0]            emit_ff, emit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_last_ff, rsp_last_in;
   tkm_pkg::entry_type       rsp_data_ff, rsp_data_in;
   tkm_pkg::entry_type       carry_ff, carry_in;

   tkm_pkg::entry_type       mem [MAX_KEEP];
   tkm_pkg::entry_type       rd_a_ff;
   tkm_pkg::entry_type       rd_b_ff;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   tkm_pkg::entry_type       wr_data;
   logic [AW-1:0]            rd_addr_a;
   logic [AW-1:0]            rd_addr_b;

   logic [RW-1:0]            row_len;
   logic [KW-1:0]            k_sat;
   logic [KW-1:0]            k;
   logic [CW-1:0]            left_idx;
   logic [CW-1:0]            right_idx;
   logic                     right_ok;
   logic                     accept;
   logic                     row_last;
   logic                     emit_load;
   logic                     emit_final;
   tkm_pkg::entry_type       item;
   tkm_pkg::sift_dec_type    dec;
   state_type                done_state;

   // Row length zero stands for 65536; the kept count is clamped to MAX_KEEP and the row.
   assign row_len = (nf_ff == '0) ? (RW'(1) << tkm_pkg::NF_W) : RW'(nf_ff);
   assign k_sat   = (kc_ff > tkm_pkg::KC_W'(MAX_KEEP)) ? KW'(MAX_KEEP) : KW'(kc_ff);
   assign k       = (RW'(k_sat) > row_len) ? KW'(row_len) : k_sat;

   assign left_idx  = (CW'(p_ff) << 1) + CW'(1);
   assign right_idx = left_idx + CW'(1);
   assign right_ok  = (state_ff == ST_SIFT_CMP) && (right_idx < CW'(k));

   assign accept   = req_ch.valid && (state_ff == ST_IDLE);
   assign row_last = (RW'(pos_ff) + RW'(1)) == row_len;
   assign item     = '{value: req_ch.value_bits, index: pos_ff};

   assign emit_load  = (state_ff == ST_EMIT_LD) && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_final = (KW'(emit_ff) + KW'(1)) == k;
   assign done_state = last_ff ? ST_EMIT_RD : ST_IDLE;

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.feature_index   = rsp_data_ff.index;
   assign rsp_ch.kept_value_bits = rsp_data_ff.value;
   assign rsp_ch.last_of_row     = rsp_last_ff;

   tkm_sift_cmp u_cmp (
      .left     (rd_a_ff),
      .right    (rd_b_ff),
      .carry    (carry_ff),
      .right_ok (right_ok),
      .dec      (dec)
   );

   always_comb begin
      unique case (state_ff)
         ST_SIFT_RD:              rd_addr_a = left_idx[AW-1:0];
         ST_BUILD_RD:             rd_addr_a = pb_ff;
         ST_EMIT_RD, ST_EMIT_LD:  rd_addr_a = emit_ff;
         default:                 rd_addr_a = '0;
      endcase
      rd_addr_b = right_idx[AW-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      nf_in        = nf_ff;
      kc_in        = kc_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      building_in  = building_ff;
      p_in         = p_ff;
      pb_in        = pb_ff;
      emit_in      = emit_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = p_ff;
      wr_data      = carry_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in     = row_last;
               pos_in      = row_last ? '0 : pos_ff + tkm_pkg::NF_W'(1);
               emit_in     = '0;
               carry_in    = item;
               building_in = 1'b0;
               if (pos_ff < tkm_pkg::NF_W'(k)) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff[AW-1:0];
                  wr_data = item;
                  if (((RW'(pos_ff) + RW'(1)) == RW'(k)) && (k > KW'(1))) begin
                     // Heap is full: heapify from the last parent down to the root.
                     pb_in       = AW'((k >> 1) - KW'(1));
                     building_in = 1'b1;
                     state_in    = ST_BUILD_RD;
                  end else if (row_last) begin
                     state_in = ST_EMIT_RD;
                  end
               end else if (k != '0) begin
                  // The root is being read this cycle for the replace test.
                  state_in = ST_ROOT_CMP;
               end
            end
         end
         ST_ROOT_CMP: begin
            if (dec.descend) begin
               p_in     = '0;
               state_in = ST_SIFT_RD;
            end else begin
               state_in = done_state;
            end
         end
         ST_SIFT_RD: begin
            if (left_idx >= CW'(k)) begin
               wr_en = 1'b1;
               if (building_ff && (pb_ff != '0)) begin
                  pb_in    = pb_ff - AW'(1);
                  state_in = ST_BUILD_RD;
               end else begin
                  building_in = 1'b0;
                  state_in    = done_state;
               end
            end else begin
               state_in = ST_SIFT_CMP;
            end
         end
         ST_SIFT_CMP: begin
            wr_en = 1'b1;
            if (dec.descend) begin
               // Move the smaller child up into the hole and follow it down.
               wr_data  = dec.pick_right ? rd_b_ff : rd_a_ff;
               p_in     = dec.pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
               state_in = ST_SIFT_RD;
            end else if (building_ff && (pb_ff != '0)) begin
               pb_in    = pb_ff - AW'(1);
               state_in = ST_BUILD_RD;
            end else begin
               building_in = 1'b0;
               state_in    = done_state;
            end
         end
         ST_BUILD_RD: begin
            state_in = ST_BUILD_LD;
         end
         ST_BUILD_LD: begin
            carry_in = rd_a_ff;
            p_in     = pb_ff;
            state_in = ST_SIFT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_a_ff;
               rsp_last_in  = emit_final;
               if (emit_final) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Any register write abandons the row in progress.
      if (csr_wr_en) begin
         unique case (tkm_pkg::csr_idx_type'(csr_index))
            tkm_pkg::CSR_ROW_LENGTH: begin
               nf_in  = csr_wdata[tkm_pkg::NF_W-1:0];
               pos_in = '0;
            end
            tkm_pkg::CSR_KEEP_COUNT: begin
               kc_in  = csr_wdata[tkm_pkg::KC_W-1:0];
               pos_in = '0;
            end
            default: begin
               nf_in = nf_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nf_ff        <= tkm_pkg::NF_W'(1);
         kc_ff        <= tkm_pkg::KC_W'(1);
         pos_ff       <= '0;
         last_ff      <= 1'b0;
         building_ff  <= 1'b0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         kc_ff        <= kc_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         building_ff  <= building_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff        <= p_in;
      pb_ff       <= pb_in;
      carry_ff    <= carry_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) |-> (KW'(emit_ff) < k))
      else $error("emit counter beyond kept count");

   a_sift_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIFT_RD || state_ff == ST_SIFT_CMP) |-> (KW'(p_ff) < k))
      else $error("sift node outside the heap");

   a_no_write_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) |-> !wr_en)
      else $error("heap written during emission");

   a_last_ends_row: assert property (@(posedge clock) disable iff (reset)
      (emit_load && emit_final) |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("row end did not return to idle");

endmodule
